FILE: design/gsfr_pkg.sv
// gsfr_pkg: constants and types shared by the gas sensor frame receiver
// no dependencies; compile first
`default_nettype none

package gsfr_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'h55;

    localparam int FRAME_LEN = 19;
    localparam int STORE_LEN = FRAME_LEN - 1;
    localparam int CNT_W     = $clog2(FRAME_LEN);
    localparam int SLOW_BASE = 12;

    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_LEN - 1);

    localparam logic [7:0] ID_INSP   = 8'd0;
    localparam logic [7:0] ID_EXP    = 8'd1;
    localparam logic [7:0] ID_IDS    = 8'd3;
    localparam logic [7:0] ID_STATUS = 8'd4;
    localparam logic [7:0] ID_CONFIG = 8'd5;
    localparam logic [7:0] ID_ZERO   = 8'd6;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_CO2  = 2'd1;
    localparam logic [1:0] KIND_AA   = 2'd2;

    localparam int         KIND_AA_BIT  = 2;
    localparam int         KIND_CO2_BIT = 1;
    localparam logic [7:0] ZERO_MASK    = 8'h03;

    typedef logic [STORE_LEN-1:0][7:0] t_frame_bytes;

    typedef struct packed {
        logic         fire;
        logic         good;
        t_frame_bytes bytes;
    } t_frame_evt;

    typedef struct packed {
        logic        status;
        logic [7:0]  frame_id;
        logic [15:0] co2;
        logic [15:0] n2o;
        logic [15:0] agent_one;
        logic [15:0] agent_two;
        logic [15:0] oxygen;
        logic [31:0] insp_values;
        logic [31:0] exp_values;
        logic [31:0] ids_and_pressure;
        logic [23:0] sensor_status;
        logic [10:0] module_info;
    } t_result;

endpackage

`default_nettype wire

FILE: design/gsfr_if.sv
// gsfr_in_if / gsfr_out_if: valid-ready channels of the frame receiver
// no dependencies
`default_nettype none

interface gsfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gsfr_out_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [7:0]  frame_id;
    logic [15:0] co2;
    logic [15:0] n2o;
    logic [15:0] agent_one;
    logic [15:0] agent_two;
    logic [15:0] oxygen;
    logic [31:0] insp_values;
    logic [31:0] exp_values;
    logic [31:0] ids_and_pressure;
    logic [23:0] sensor_status;
    logic [10:0] module_info;

    modport source (
        output valid, output status, output frame_id, output co2, output n2o,
        output agent_one, output agent_two, output oxygen, output insp_values,
        output exp_values, output ids_and_pressure, output sensor_status,
        output module_info, input ready
    );
    modport sink (
        input valid, input status, input frame_id, input co2, input n2o,
        input agent_one, input agent_two, input oxygen, input insp_values,
        input exp_values, input ids_and_pressure, input sensor_status,
        input module_info, output ready
    );
endinterface

`default_nettype wire

FILE: design/gsfr_collector.sv
// gsfr_collector: sync hunt, frame byte capture and running checksum
// depends on gsfr_pkg
`default_nettype none

module gsfr_collector (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_byte,
    input  logic                i_res_free,
    output logic                o_ready,
    output gsfr_pkg::t_frame_evt o_evt
);

    logic                       r_hunting;
    logic [7:0]                 r_prev;
    logic [gsfr_pkg::CNT_W-1:0] r_count;
    logic [7:0]                 r_sum;
    gsfr_pkg::t_frame_bytes     r_frame;

    logic                       n_hunting;
    logic [7:0]                 n_prev;
    logic [gsfr_pkg::CNT_W-1:0] n_count;
    logic [7:0]                 n_sum;

    logic fire;
    logic last_pending;
    logic [7:0] sum_next;

    assign last_pending = !r_hunting && (r_count == gsfr_pkg::LAST_IDX);
    assign o_ready      = !last_pending || i_res_free;
    assign fire         = i_valid && o_ready;
    assign sum_next     = r_sum + i_byte;

    always_comb begin
        n_hunting = r_hunting;
        n_prev    = r_prev;
        n_count   = r_count;
        n_sum     = r_sum;
        if (fire) begin
            if (r_hunting) begin
                if (r_prev == gsfr_pkg::SYNC_FIRST && i_byte == gsfr_pkg::SYNC_SECOND) begin
                    n_hunting = 1'b0;
                end
                n_prev = i_byte;
            end else if (last_pending) begin
                n_hunting = 1'b1;
                n_prev    = '0;
                n_count   = '0;
                n_sum     = '0;
            end else begin
                n_count = r_count + gsfr_pkg::CNT_W'(1);
                n_sum   = sum_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunting <= 1'b1;
            r_prev    <= '0;
            r_count   <= '0;
            r_sum     <= '0;
        end else begin
            r_hunting <= n_hunting;
            r_prev    <= n_prev;
            r_count   <= n_count;
            r_sum     <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && !r_hunting && !last_pending) begin
            r_frame[r_count] <= i_byte;
        end
    end

    assign o_evt.fire  = fire && last_pending;
    assign o_evt.good  = (sum_next == 8'd0);
    assign o_evt.bytes = r_frame;

endmodule

`default_nettype wire

FILE: design/gsfr_decoder.sv
// gsfr_decoder: slow-data record stores and the result register
// depends on gsfr_pkg
`default_nettype none

module gsfr_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gsfr_pkg::t_frame_evt i_evt,
    input  logic                 i_out_ready,
    output logic                 o_res_free,
    output logic                 o_valid,
    output gsfr_pkg::t_result    o_res
);

    logic              r_valid;
    gsfr_pkg::t_result r_res;
    logic [31:0]       r_insp;
    logic [31:0]       r_exp;
    logic [31:0]       r_ids;
    logic [23:0]       r_stat;
    logic [7:0]        r_cfg;
    logic [1:0]        r_kind;
    logic              r_zero;

    gsfr_pkg::t_result n_res;
    logic [31:0]       n_insp;
    logic [31:0]       n_exp;
    logic [31:0]       n_ids;
    logic [23:0]       n_stat;
    logic [7:0]        n_cfg;
    logic [1:0]        n_kind;
    logic              n_zero;

    logic [7:0] s0, s1, s2, s3, s4, s5;
    logic [7:0] id;
    logic       upd;

    assign id  = i_evt.bytes[0];
    assign s0  = i_evt.bytes[gsfr_pkg::SLOW_BASE + 0];
    assign s1  = i_evt.bytes[gsfr_pkg::SLOW_BASE + 1];
    assign s2  = i_evt.bytes[gsfr_pkg::SLOW_BASE + 2];
    assign s3  = i_evt.bytes[gsfr_pkg::SLOW_BASE + 3];
    assign s4  = i_evt.bytes[gsfr_pkg::SLOW_BASE + 4];
    assign s5  = i_evt.bytes[gsfr_pkg::SLOW_BASE + 5];
    assign upd = i_evt.fire && i_evt.good;

    assign o_res_free = !r_valid || i_out_ready;

    always_comb begin
        n_insp = r_insp;
        n_exp  = r_exp;
        n_ids  = r_ids;
        n_stat = r_stat;
        n_cfg  = r_cfg;
        n_kind = r_kind;
        n_zero = r_zero;
        if (upd) begin
            unique case (id)
                gsfr_pkg::ID_INSP:   n_insp = {s3, s2, s1, s0};
                gsfr_pkg::ID_EXP:    n_exp  = {s3, s2, s1, s0};
                gsfr_pkg::ID_IDS:    n_ids  = {s2, s3, s4, s5};
                gsfr_pkg::ID_STATUS: n_stat = {s2, s3, s4};
                gsfr_pkg::ID_CONFIG: begin
                    n_cfg = s0;
                    if (s0[gsfr_pkg::KIND_AA_BIT]) begin
                        n_kind = gsfr_pkg::KIND_AA;
                    end else if (s0[gsfr_pkg::KIND_CO2_BIT]) begin
                        n_kind = gsfr_pkg::KIND_CO2;
                    end else begin
                        n_kind = gsfr_pkg::KIND_NONE;
                    end
                end
                gsfr_pkg::ID_ZERO:   n_zero = ((s2 & gsfr_pkg::ZERO_MASK) == 8'd0);
                default: ;
            endcase
        end
    end

    always_comb begin
        n_res.status           = !i_evt.good;
        n_res.frame_id         = id;
        n_res.co2              = i_evt.good ? {i_evt.bytes[2],  i_evt.bytes[3]}  : 16'd0;
        n_res.n2o              = i_evt.good ? {i_evt.bytes[4],  i_evt.bytes[5]}  : 16'd0;
        n_res.agent_one        = i_evt.good ? {i_evt.bytes[6],  i_evt.bytes[7]}  : 16'd0;
        n_res.agent_two        = i_evt.good ? {i_evt.bytes[8],  i_evt.bytes[9]}  : 16'd0;
        n_res.oxygen           = i_evt.good ? {i_evt.bytes[10], i_evt.bytes[11]} : 16'd0;
        n_res.insp_values      = n_insp;
        n_res.exp_values       = n_exp;
        n_res.ids_and_pressure = n_ids;
        n_res.sensor_status    = n_stat;
        n_res.module_info      = {n_cfg, n_kind, n_zero};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_insp  <= '0;
            r_exp   <= '0;
            r_ids   <= '0;
            r_stat  <= '0;
            r_cfg   <= '0;
            r_kind  <= gsfr_pkg::KIND_NONE;
            r_zero  <= 1'b0;
        end else begin
            r_insp <= n_insp;
            r_exp  <= n_exp;
            r_ids  <= n_ids;
            r_stat <= n_stat;
            r_cfg  <= n_cfg;
            r_kind <= n_kind;
            r_zero <= n_zero;
            if (i_evt.fire) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.fire) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

FILE: design/gas_sensor_frame_receiver_top.sv
// gas_sensor_frame_receiver_top: byte-in, frame-result-out gas sensor receiver
// depends on gsfr_pkg, gsfr_if, gsfr_collector, gsfr_decoder
//
// usage
//   i_rx carries one received byte per beat; o_res carries one result per
//   completed 19-byte frame. The block hunts for 0xAA 0x55, then captures the
//   next 19 bytes; byte count and checksum update on every frame byte.
// throughput
//   one byte per cycle (capture register and sum) unless the last byte stalls.
// latency
//   the result beat is valid the cycle after the last frame byte is taken.
// stalls
//   only the last byte of a frame waits for the result register to be free;
//   hunting and other frame bytes are taken while a result is still pending.
// reset
//   synchronous, active low: hunting for sync, count and sum cleared, held
//   slow records cleared to zero, no result pending.
`default_nettype none

module gas_sensor_frame_receiver_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gsfr_in_if.sink     i_rx,
    gsfr_out_if.source  o_res
);

    gsfr_pkg::t_frame_evt evt;
    gsfr_pkg::t_result    res;
    logic                 res_free;
    logic                 res_valid;

    gsfr_collector u_collector (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_rx.valid),
        .i_byte     (i_rx.rx_byte),
        .i_res_free (res_free),
        .o_ready    (i_rx.ready),
        .o_evt      (evt)
    );

    gsfr_decoder u_decoder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (evt),
        .i_out_ready (o_res.ready),
        .o_res_free  (res_free),
        .o_valid     (res_valid),
        .o_res       (res)
    );

    assign o_res.valid            = res_valid;
    assign o_res.status           = res.status;
    assign o_res.frame_id         = res.frame_id;
    assign o_res.co2              = res.co2;
    assign o_res.n2o              = res.n2o;
    assign o_res.agent_one        = res.agent_one;
    assign o_res.agent_two        = res.agent_two;
    assign o_res.oxygen           = res.oxygen;
    assign o_res.insp_values      = res.insp_values;
    assign o_res.exp_values       = res.exp_values;
    assign o_res.ids_and_pressure = res.ids_and_pressure;
    assign o_res.sensor_status    = res.sensor_status;
    assign o_res.module_info      = res.module_info;

endmodule

`default_nettype wire

FILE: dv/gas_sensor_frame_receiver_top_tb.sv
// gas_sensor_frame_receiver_top_tb: self-checking bench for the gas sensor frame receiver
// drives byte beats, predicts frame results and held slow records, checks each result beat
// depends on gsfr_pkg, gsfr_if and gas_sensor_frame_receiver_top
`timescale 1ns / 1ps

module gas_sensor_frame_receiver_top_tb;
    import gsfr_pkg::*;

    typedef logic [7:0] t_raw_frame [FRAME_LEN];

    logic i_clk = 1'b0;
    logic i_rst_n;

    gsfr_in_if  rx_ch ();
    gsfr_out_if res_ch ();

    gas_sensor_frame_receiver_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch)
    );

    always #4 i_clk = ~i_clk;

    // receiver model state
    logic        hunting     = 1'b1;
    logic [7:0]  last_rx     = 8'h00;
    int          taken       = 0;
    logic [7:0]  sum_acc     = 8'h00;
    logic [7:0]  frame_bytes [FRAME_LEN];
    logic [31:0] insp_hold   = '0;
    logic [31:0] exp_hold    = '0;
    logic [31:0] ids_hold    = '0;
    logic [23:0] status_hold = '0;
    logic [7:0]  cfg_hold    = '0;
    logic [1:0]  kind_hold   = KIND_NONE;
    logic        zero_hold   = 1'b0;

    t_result     frame_results [$];
    int          mismatches  = 0;
    int          bytes_sent  = 0;
    bit          rx_calm     = 1'b0;
    bit          res_calm    = 1'b0;

    function automatic logic [7:0] slow_byte(int k);
        return frame_bytes[SLOW_BASE + k];
    endfunction

    function automatic void predict_byte(logic [7:0] b);
        t_result    r;
        logic       good;
        logic [7:0] cfg_byte;
        if (hunting) begin
            if (last_rx == SYNC_FIRST && b == SYNC_SECOND) hunting = 1'b0;
            last_rx = b;
            return;
        end
        frame_bytes[taken] = b;
        sum_acc = sum_acc + b;
        taken++;
        if (taken < FRAME_LEN) return;

        good = (sum_acc == 8'h00);
        if (good) begin
            case (frame_bytes[0])
                ID_INSP: insp_hold = {slow_byte(3), slow_byte(2), slow_byte(1), slow_byte(0)};
                ID_EXP: exp_hold = {slow_byte(3), slow_byte(2), slow_byte(1), slow_byte(0)};
                ID_IDS: ids_hold = {slow_byte(2), slow_byte(3), slow_byte(4), slow_byte(5)};
                ID_STATUS: status_hold = {slow_byte(2), slow_byte(3), slow_byte(4)};
                ID_CONFIG: begin
                    cfg_byte = slow_byte(0);
                    cfg_hold = cfg_byte;
                    if (cfg_byte[KIND_AA_BIT]) kind_hold = KIND_AA;
                    else if (cfg_byte[KIND_CO2_BIT]) kind_hold = KIND_CO2;
                    else kind_hold = KIND_NONE;
                end
                ID_ZERO: zero_hold = ((slow_byte(2) & ZERO_MASK) == 8'h00);
                default: ;
            endcase
        end

        r.status           = ~good;
        r.frame_id         = frame_bytes[0];
        r.co2              = good ? {frame_bytes[2], frame_bytes[3]} : 16'h0;
        r.n2o              = good ? {frame_bytes[4], frame_bytes[5]} : 16'h0;
        r.agent_one        = good ? {frame_bytes[6], frame_bytes[7]} : 16'h0;
        r.agent_two        = good ? {frame_bytes[8], frame_bytes[9]} : 16'h0;
        r.oxygen           = good ? {frame_bytes[10], frame_bytes[11]} : 16'h0;
        r.insp_values      = insp_hold;
        r.exp_values       = exp_hold;
        r.ids_and_pressure = ids_hold;
        r.sensor_status    = status_hold;
        r.module_info      = {cfg_hold, kind_hold, zero_hold};
        frame_results.push_back(r);

        hunting = 1'b1;
        taken   = 0;
        sum_acc = 8'h00;
        last_rx = 8'h00;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    function automatic int idle_draw(bit calm);
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    // one byte beat
    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = idle_draw(rx_calm);
        @(negedge i_clk);
        if (gap > 0) begin
            rx_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        rx_ch.valid   = 1'b1;
        rx_ch.rx_byte = b;
        @(posedge i_clk);
        while (!rx_ch.ready) @(posedge i_clk);
        bytes_sent++;
        predict_byte(b);
    endtask

    // sync pair, 18 frame bytes, check byte
    task automatic send_frame(t_raw_frame f, bit bad_sum);
        logic [7:0] sum;
        sum = 8'h00;
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
            send_byte(f[i]);
            sum = sum + f[i];
        end
        sum = 8'h00 - sum;
        if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
        send_byte(sum);
    endtask

    function automatic t_raw_frame raw_frame(logic [7:0] id, logic [7:0] fill);
        t_raw_frame f;
        foreach (f[i]) f[i] = fill;
        f[0] = id;
        return f;
    endfunction

    function automatic t_raw_frame random_frame(logic [7:0] id);
        t_raw_frame f;
        foreach (f[i]) f[i] = 8'($urandom);
        f[0] = id;
        return f;
    endfunction

    task automatic test_each_record();
        t_raw_frame f;
        logic [7:0] cfg_cases [3] = '{8'h06, 8'h02, 8'hF9};
        send_frame(raw_frame(ID_INSP, 8'hFF), 1'b0);
        send_frame(raw_frame(ID_EXP, 8'h00), 1'b0);
        send_frame(raw_frame(ID_IDS, 8'h5A), 1'b0);
        send_frame(raw_frame(ID_STATUS, 8'hA5), 1'b0);
        foreach (cfg_cases[i]) begin
            f = raw_frame(ID_CONFIG, 8'h00);
            f[SLOW_BASE] = cfg_cases[i];
            send_frame(f, 1'b0);
        end
        f = raw_frame(ID_ZERO, 8'h00);
        f[SLOW_BASE + 2] = 8'hFC;
        send_frame(f, 1'b0);
        f[SLOW_BASE + 2] = 8'h01;
        send_frame(f, 1'b0);
    endtask

    task automatic test_bad_and_unknown();
        send_frame(raw_frame(ID_INSP, 8'h11), 1'b1);
        send_frame(raw_frame(ID_CONFIG, 8'hFF), 1'b1);
        send_frame(raw_frame(8'd2, 8'h33), 1'b0);
        send_frame(raw_frame(8'd7, 8'hCC), 1'b0);
        send_frame(raw_frame(8'hFF, 8'hFF), 1'b0);
    endtask

    task automatic test_sync_hunting();
        t_raw_frame f;
        logic [7:0] sum;
        // noise and a doubled first sync byte
        send_byte(SYNC_SECOND);
        send_byte(SYNC_FIRST);
        send_byte(8'h00);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        f = raw_frame(ID_EXP, SYNC_FIRST);
        f[3] = SYNC_SECOND;
        f[SLOW_BASE + 1] = SYNC_SECOND;
        sum = 8'h00;
        for (int i = 0; i < FRAME_LEN - 1; i++) sum = sum + f[i];
        for (int i = 0; i < FRAME_LEN - 1; i++) send_byte(f[i]);
        send_byte(8'h00 - sum);
        // check byte equal to the first sync byte, then the second: no new sync
        f = raw_frame(ID_IDS, 8'h77);
        f[1] = 8'h00;
        sum = 8'h00;
        for (int i = 0; i < FRAME_LEN - 1; i++) sum = sum + f[i];
        f[1] = (8'h00 - SYNC_FIRST) - sum;
        send_frame(f, 1'b0);
        send_byte(SYNC_SECOND);
        for (int i = 0; i < FRAME_LEN; i++) send_byte(f[i]);
        send_frame(raw_frame(ID_STATUS, 8'h3C), 1'b0);
    endtask

    task automatic test_drain_pause();
        send_frame(random_frame(ID_INSP), 1'b0);
        @(negedge i_clk);
        rx_ch.valid = 1'b0;
        while (frame_results.size() > 0) @(posedge i_clk);
        send_frame(random_frame(ID_EXP), 1'b0);
        send_frame(random_frame(ID_IDS), 1'b0);
    endtask

    task automatic test_random_traffic();
        logic [7:0] known_ids [6] = '{ID_INSP, ID_EXP, ID_IDS, ID_STATUS, ID_CONFIG, ID_ZERO};
        logic [7:0] id;
        int         pick;
        int         goal;
        goal = 1500;
        while (bytes_sent < goal) begin
            if ($urandom_range(0, 15) == 0) rx_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 15) == 0) res_calm = ($urandom_range(0, 3) == 0);
            id = ($urandom_range(0, 9) < 7) ? known_ids[$urandom_range(0, 5)] : 8'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                send_frame(random_frame(id), 1'b0);
            end else if (pick < 85) begin
                send_frame(random_frame(id), 1'b1);
            end else if (pick < 93) begin
                repeat ($urandom_range(1, 8))
                    send_byte(($urandom_range(0, 3) == 0) ? SYNC_FIRST : 8'($urandom));
            end else if (pick < 97) begin
                send_byte(SYNC_FIRST);
                send_byte(8'($urandom_range(0, 255)) ^ (($urandom & 1) ? 8'h00 : 8'hFF));
            end else begin
                send_byte(SYNC_FIRST);
                send_byte(SYNC_SECOND);
                repeat ($urandom_range(1, FRAME_LEN - 1)) send_byte(8'($urandom));
            end
        end
        rx_calm  = 1'b0;
        res_calm = 1'b0;
    endtask

    // result side: random stalls, compare each result beat
    initial begin
        t_result seen;
        t_result want;
        int      gap;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = idle_draw(res_calm);
            @(negedge i_clk);
            if (gap > 0) begin
                res_ch.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            res_ch.ready = 1'b1;
            @(posedge i_clk);
            while (res_ch.valid !== 1'b1) @(posedge i_clk);
            seen.status           = res_ch.status;
            seen.frame_id         = res_ch.frame_id;
            seen.co2              = res_ch.co2;
            seen.n2o              = res_ch.n2o;
            seen.agent_one        = res_ch.agent_one;
            seen.agent_two        = res_ch.agent_two;
            seen.oxygen           = res_ch.oxygen;
            seen.insp_values      = res_ch.insp_values;
            seen.exp_values       = res_ch.exp_values;
            seen.ids_and_pressure = res_ch.ids_and_pressure;
            seen.sensor_status    = res_ch.sensor_status;
            seen.module_info      = res_ch.module_info;
            if (frame_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat, frame_id %h", seen.frame_id));
            end else begin
                want = frame_results.pop_front();
                check_field("status", 32'(seen.status), 32'(want.status));
                check_field("frame_id", 32'(seen.frame_id), 32'(want.frame_id));
                check_field("co2", 32'(seen.co2), 32'(want.co2));
                check_field("n2o", 32'(seen.n2o), 32'(want.n2o));
                check_field("agent_one", 32'(seen.agent_one), 32'(want.agent_one));
                check_field("agent_two", 32'(seen.agent_two), 32'(want.agent_two));
                check_field("oxygen", 32'(seen.oxygen), 32'(want.oxygen));
                check_field("insp_values", seen.insp_values, want.insp_values);
                check_field("exp_values", seen.exp_values, want.exp_values);
                check_field("ids_and_pressure", seen.ids_and_pressure, want.ids_and_pressure);
                check_field("sensor_status", 32'(seen.sensor_status),
                            32'(want.sensor_status));
                check_field("module_info", 32'(seen.module_info), 32'(want.module_info));
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_each_record();
        test_bad_and_unknown();
        test_sync_hunting();
        test_drain_pause();
        test_random_traffic();

        @(negedge i_clk);
        rx_ch.valid = 1'b0;
        while (frame_results.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
